/* rtl/bogm_pkg.sv */
// Shared types, codes and constants of the box outline glyph map.
package bogm_pkg;

   // Field widths fixed by the interface.
   localparam int COORD_W = 9;
   localparam int SIZE_W  = 9;
   localparam int GLYPH_W = 14;
   localparam int MASK_W  = 4;
   localparam int CSR_W   = 8;
   localparam int AW_W    = 8;
   localparam int AH_W    = 6;
   // Signed working width for edge arithmetic: x + w - 1 reaches 765.
   localparam int EXT_W   = 11;

   // Configuration register indexes and reset values.
   typedef logic csr_index_type;
   localparam csr_index_type CSR_ACTIVE_WIDTH  = 1'b0;
   localparam csr_index_type CSR_ACTIVE_HEIGHT = 1'b1;
   localparam logic [AW_W-1:0] ACTIVE_WIDTH_RESET  = 8'd80;
   localparam logic [AH_W-1:0] ACTIVE_HEIGHT_RESET = 6'd25;

   // Request type codes.
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Row read address selection.
   typedef logic [1:0] rd_sel_type;
   localparam rd_sel_type RD_ROW  = 2'd0;
   localparam rd_sel_type RD_MID  = 2'd1;
   localparam rd_sel_type RD_UP   = 2'd2;
   localparam rd_sel_type RD_DOWN = 2'd3;

   // Box-drawing code points.
   localparam logic [GLYPH_W-1:0] GLYPH_SPACE      = 14'h0020;
   localparam logic [GLYPH_W-1:0] GLYPH_DOWN_RIGHT = 14'h250C;
   localparam logic [GLYPH_W-1:0] GLYPH_DOWN_LEFT  = 14'h2510;
   localparam logic [GLYPH_W-1:0] GLYPH_UP_RIGHT   = 14'h2514;
   localparam logic [GLYPH_W-1:0] GLYPH_UP_LEFT    = 14'h2518;
   localparam logic [GLYPH_W-1:0] GLYPH_HORIZ      = 14'h2500;
   localparam logic [GLYPH_W-1:0] GLYPH_VERT       = 14'h2502;
   localparam logic [GLYPH_W-1:0] GLYPH_VERT_RIGHT = 14'h251C;
   localparam logic [GLYPH_W-1:0] GLYPH_VERT_LEFT  = 14'h2524;
   localparam logic [GLYPH_W-1:0] GLYPH_HORIZ_DOWN = 14'h252C;
   localparam logic [GLYPH_W-1:0] GLYPH_HORIZ_UP   = 14'h2534;
   localparam logic [GLYPH_W-1:0] GLYPH_CROSS      = 14'h253C;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       add_setup;
      logic       row_step;
      logic       clear_we;
      logic       add_we;
      rd_sel_type rd_sel;
      logic       lat_mid;
      logic       lat_up;
      logic       lat_down;
      logic       load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_query;
      logic add_empty;
      logic add_last;
      logic clear_last;
      logic rsp_free;
   } status_type;

   // Mask bits: 3 left, 2 below, 1 right, 0 above.
   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [MASK_W-1:0] mask);
      logic [GLYPH_W-1:0] g;
      case (mask)
         4'd3:    g = GLYPH_UP_RIGHT;
         4'd5:    g = GLYPH_VERT;
         4'd6:    g = GLYPH_DOWN_RIGHT;
         4'd7:    g = GLYPH_VERT_RIGHT;
         4'd9:    g = GLYPH_UP_LEFT;
         4'd10:   g = GLYPH_HORIZ;
         4'd11:   g = GLYPH_HORIZ_UP;
         4'd12:   g = GLYPH_DOWN_LEFT;
         4'd13:   g = GLYPH_VERT_LEFT;
         4'd14:   g = GLYPH_HORIZ_DOWN;
         4'd15:   g = GLYPH_CROSS;
         default: g = GLYPH_SPACE;
      endcase
      return g;
   endfunction

endpackage

/* rtl/bogm_if.sv */
// Request and response channel interfaces of the box outline glyph map.
interface bogm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic signed [bogm_pkg::COORD_W-1:0] coord_x;
   logic signed [bogm_pkg::COORD_W-1:0] coord_y;
   logic        [bogm_pkg::SIZE_W-1:0]  rect_width;
   logic        [bogm_pkg::SIZE_W-1:0]  rect_height;

   modport source (output valid, req_type, coord_x, coord_y, rect_width, rect_height,
                   input ready);
   modport sink   (input valid, req_type, coord_x, coord_y, rect_width, rect_height,
                   output ready);
endinterface

interface bogm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bogm_pkg::GLYPH_W-1:0]  glyph_code;
   logic [bogm_pkg::MASK_W-1:0]   neighbour_mask;

   modport source (output valid, glyph_code, neighbour_mask, input ready);
   modport sink   (input valid, glyph_code, neighbour_mask, output ready);
endinterface

/* rtl/bogm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module bogm_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bogm_ctrl.sv */
// Controller state machine of the box outline glyph map.
module bogm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output bogm_pkg::cmd_type    cmd,
   input  bogm_pkg::status_type status
);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_START     = 4'd2;
   localparam logic [3:0] S_ADD_READ  = 4'd3;
   localparam logic [3:0] S_ADD_WRITE = 4'd4;
   localparam logic [3:0] S_Q_UP      = 4'd5;
   localparam logic [3:0] S_Q_DOWN    = 4'd6;
   localparam logic [3:0] S_Q_LAST    = 4'd7;
   localparam logic [3:0] S_DONE      = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = bogm_pkg::RD_ROW;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_we = 1'b1;
            cmd.row_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (status.is_query) begin
               cmd.rd_sel = bogm_pkg::RD_MID;
               state_in   = S_Q_UP;
            end else begin
               cmd.add_setup = 1'b1;
               state_in      = status.add_empty ? S_DONE : S_ADD_READ;
            end
         end
         S_ADD_READ: begin
            state_in = S_ADD_WRITE;
         end
         S_ADD_WRITE: begin
            cmd.add_we = 1'b1;
            if (status.add_last) begin
               state_in = S_DONE;
            end else begin
               cmd.row_step = 1'b1;
               state_in     = S_ADD_READ;
            end
         end
         S_Q_UP: begin
            cmd.lat_mid = 1'b1;
            cmd.rd_sel  = bogm_pkg::RD_UP;
            state_in    = S_Q_DOWN;
         end
         S_Q_DOWN: begin
            cmd.lat_up = 1'b1;
            cmd.rd_sel = bogm_pkg::RD_DOWN;
            state_in   = S_Q_LAST;
         end
         S_Q_LAST: begin
            cmd.lat_down = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/bogm_dp.sv */
// Datapath of the box outline glyph map: line map, row masks and result register.
module bogm_dp #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bogm_pkg::cmd_type                   cmd,
   output bogm_pkg::status_type                status,
   input  logic                                req_type,
   input  logic signed [bogm_pkg::COORD_W-1:0] coord_x,
   input  logic signed [bogm_pkg::COORD_W-1:0] coord_y,
   input  logic        [bogm_pkg::SIZE_W-1:0]  rect_width,
   input  logic        [bogm_pkg::SIZE_W-1:0]  rect_height,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic        [bogm_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic        [bogm_pkg::GLYPH_W-1:0] glyph_code,
   output logic        [bogm_pkg::MASK_W-1:0]  neighbour_mask
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int EW = bogm_pkg::EXT_W;
   localparam logic signed [EW-1:0] MAX_W_EXT = EW'(MAX_WIDTH);
   localparam logic signed [EW-1:0] MAX_H_EXT = EW'(MAX_HEIGHT);
   localparam logic [RW-1:0]        ROW_LAST  = RW'(MAX_HEIGHT - 1);

   // Configuration registers.
   logic [bogm_pkg::AW_W-1:0] active_width_ff;
   logic [bogm_pkg::AH_W-1:0] active_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff  <= bogm_pkg::ACTIVE_WIDTH_RESET;
         active_height_ff <= bogm_pkg::ACTIVE_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bogm_pkg::CSR_ACTIVE_WIDTH:  active_width_ff  <= csr_wdata;
            bogm_pkg::CSR_ACTIVE_HEIGHT: active_height_ff <= csr_wdata[bogm_pkg::AH_W-1:0];
            default: ;
         endcase
      end
   end

   // Active grid size, saturated to the map size.
   logic signed [EW-1:0] aw_ext;
   logic signed [EW-1:0] ah_ext;
   logic signed [EW-1:0] grid_w;
   logic signed [EW-1:0] grid_h;

   assign aw_ext = signed'({{(EW - bogm_pkg::AW_W){1'b0}}, active_width_ff});
   assign ah_ext = signed'({{(EW - bogm_pkg::AH_W){1'b0}}, active_height_ff});
   assign grid_w = (aw_ext > MAX_W_EXT) ? MAX_W_EXT : aw_ext;
   assign grid_h = (ah_ext > MAX_H_EXT) ? MAX_H_EXT : ah_ext;

   // Request capture at the transfer.
   logic                                req_type_ff;
   logic signed [bogm_pkg::COORD_W-1:0] x_ff;
   logic signed [bogm_pkg::COORD_W-1:0] y_ff;
   logic        [bogm_pkg::SIZE_W-1:0]  w_ff;
   logic        [bogm_pkg::SIZE_W-1:0]  h_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         x_ff        <= coord_x;
         y_ff        <= coord_y;
         w_ff        <= rect_width;
         h_ff        <= rect_height;
      end
   end

   // Rectangle edges in signed working width.
   logic signed [EW-1:0] x0;
   logic signed [EW-1:0] y0;
   logic signed [EW-1:0] x1;
   logic signed [EW-1:0] y1;
   logic signed [EW-1:0] row_lo;
   logic signed [EW-1:0] row_hi;
   logic                 add_empty;

   assign x0 = signed'({{(EW - bogm_pkg::COORD_W){x_ff[bogm_pkg::COORD_W-1]}}, x_ff});
   assign y0 = signed'({{(EW - bogm_pkg::COORD_W){y_ff[bogm_pkg::COORD_W-1]}}, y_ff});
   assign x1 = x0 + signed'({{(EW - bogm_pkg::SIZE_W){1'b0}}, w_ff}) - EW'(1);
   assign y1 = y0 + signed'({{(EW - bogm_pkg::SIZE_W){1'b0}}, h_ff}) - EW'(1);

   // Rows touched, clipped to the active grid.
   assign row_lo    = (y0 < EW'(0)) ? EW'(0) : y0;
   assign row_hi    = (y1 > grid_h - EW'(1)) ? grid_h - EW'(1) : y1;
   assign add_empty = (w_ff == '0) || (h_ff == '0) || (row_lo > row_hi);

   // Row pointer shared by the clearing pass and the outline walk.
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else if (cmd.add_setup) begin
         row_ff <= row_lo[RW-1:0];
      end else if (cmd.row_step) begin
         row_ff <= row_ff + RW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_setup) begin
         row_hi_ff <= row_hi[RW-1:0];
      end
   end

   // Cells to set in the current row: full span on the top and bottom edges,
   // the two side columns elsewhere, all clipped to the active width.
   logic signed [EW-1:0] row_ext;
   logic                 edge_row;
   logic [MAX_WIDTH-1:0] set_mask;

   assign row_ext  = signed'({{(EW - RW){1'b0}}, row_ff});
   assign edge_row = (row_ext == y0) || (row_ext == y1);

   for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
      localparam logic signed [EW-1:0] COL = EW'(c);
      assign set_mask[c] = (COL >= x0) && (COL <= x1) && (COL < grid_w)
                           && (edge_row || (COL == x0) || (COL == x1));
   end

   // Query geometry.
   logic          in_grid;
   logic          has_left;
   logic          has_right;
   logic          has_up;
   logic          has_down;
   logic [CW-1:0] xi;
   logic [CW-1:0] xi_left;
   logic [CW-1:0] xi_right;
   logic [RW-1:0] yi;

   assign in_grid   = (x0 >= EW'(0)) && (x0 < grid_w) && (y0 >= EW'(0)) && (y0 < grid_h);
   assign has_left  = (x0 > EW'(0));
   assign has_right = (x0 + EW'(1) < grid_w);
   assign has_up    = (y0 > EW'(0));
   assign has_down  = (y0 + EW'(1) < grid_h);
   assign xi        = x_ff[CW-1:0];
   assign xi_left   = xi - CW'(1);
   assign xi_right  = xi + CW'(1);
   assign yi        = y_ff[RW-1:0];

   // Line map, one row of cells per word.
   logic [RW-1:0]        ram_raddr;
   logic [MAX_WIDTH-1:0] ram_rdata;
   logic [MAX_WIDTH-1:0] ram_wdata;
   logic                 ram_we;

   always_comb begin
      case (cmd.rd_sel)
         bogm_pkg::RD_MID:  ram_raddr = yi;
         bogm_pkg::RD_UP:   ram_raddr = has_up ? yi - RW'(1) : yi;
         bogm_pkg::RD_DOWN: ram_raddr = has_down ? yi + RW'(1) : yi;
         default:           ram_raddr = row_ff;
      endcase
   end

   assign ram_we    = cmd.clear_we | cmd.add_we;
   assign ram_wdata = cmd.clear_we ? '0 : (ram_rdata | set_mask);

   bogm_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (row_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Neighbour bits gathered over the three row reads.
   logic center_ff;
   logic left_ff;
   logic right_ff;
   logic up_ff;
   logic down_ff;

   always_ff @(posedge clock) begin
      if (cmd.lat_mid) begin
         center_ff <= ram_rdata[xi];
         left_ff   <= has_left & ram_rdata[xi_left];
         right_ff  <= has_right & ram_rdata[xi_right];
      end
      if (cmd.lat_up) begin
         up_ff <= has_up & ram_rdata[xi];
      end
      if (cmd.lat_down) begin
         down_ff <= has_down & ram_rdata[xi];
      end
   end

   // Result value.
   logic                          hit;
   logic [bogm_pkg::MASK_W-1:0]   mask_val;
   logic [bogm_pkg::GLYPH_W-1:0]  glyph_val;

   assign hit       = (req_type_ff == bogm_pkg::REQ_QUERY) && in_grid && center_ff;
   assign mask_val  = hit ? {left_ff, down_ff, right_ff, up_ff} : '0;
   assign glyph_val = hit ? bogm_pkg::glyph_of(mask_val) : bogm_pkg::GLYPH_SPACE;

   // Output register.
   logic                         rsp_valid_ff;
   logic [bogm_pkg::GLYPH_W-1:0] glyph_ff;
   logic [bogm_pkg::MASK_W-1:0]  mask_ff;
   logic                         rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         glyph_ff <= glyph_val;
         mask_ff  <= mask_val;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign glyph_code     = glyph_ff;
   assign neighbour_mask = mask_ff;

   // Status back to the controller.
   always_comb begin
      status            = '0;
      status.is_query   = (req_type_ff == bogm_pkg::REQ_QUERY);
      status.add_empty  = add_empty;
      status.add_last   = (row_ff == row_hi_ff);
      status.clear_last = (row_ff == ROW_LAST);
      status.rsp_free   = rsp_free;
   end

   // A new result is never loaded over one still waiting to be taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("result loaded while the previous one was still pending");

   // The outline walk never writes past the last clipped row.
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.add_we |-> (row_ff <= row_hi_ff))
      else $error("outline write beyond the last row of the rectangle");

   // A drawn glyph always joins at least two lines.
   a_glyph_joins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (glyph_ff != bogm_pkg::GLYPH_SPACE)) |-> ($countones(mask_ff) >= 2))
      else $error("line glyph reported with fewer than two neighbours");

endmodule

/* rtl/box_outline_glyph_map_top.sv */
// Top level of the box outline glyph map: controller, datapath and channel wiring.
//
//   Channel   Direction  Handshake           Payload
//   req_chan  in         valid / ready       req_type, coord_x, coord_y, rect_width, rect_height
//   rsp_chan  out        valid / ready       glyph_code, neighbour_mask
//   csr_*     in         csr_we, no wait     csr_index, csr_wdata
//
// After a transfer a query reads the centre row, then the rows above and below,
// before loading the output register; an add walks the rows of the rectangle
// inside the grid, each row being one read and one write of the single-write,
// single-read line map memory. Reset starts a clearing pass, one map row a cycle;
// no request is taken during it. The next request is taken once the current one
// is finished, even while its result still waits on a stalled rsp_chan.
module box_outline_glyph_map_top #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   bogm_req_if.sink                     req_chan,
   bogm_rsp_if.source                   rsp_chan,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [bogm_pkg::CSR_W-1:0]   csr_wdata
);

   bogm_pkg::cmd_type    cmd;
   bogm_pkg::status_type status;

   // Sequencing of the clearing pass, outline walk and query reads.
   bogm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Line map, geometry and result register.
   bogm_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_chan.req_type),
      .coord_x        (req_chan.coord_x),
      .coord_y        (req_chan.coord_y),
      .rect_width     (req_chan.rect_width),
      .rect_height    (req_chan.rect_height),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .glyph_code     (rsp_chan.glyph_code),
      .neighbour_mask (rsp_chan.neighbour_mask)
   );

endmodule
